// ----- rtl/sik_pkg.sv -----
package sik_pkg;

    localparam int NUM_SLOTS    = 4;
    localparam int CORDIC_STEPS = 16;

    // 1/K of the 16-step CORDIC gain, Q0.30
    localparam logic [29:0] KINV = 30'd652032874;

    // Quarter turn in 32-bit binary angle units
    localparam logic signed [33:0] QUARTER_Z = 34'sd1073741824;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_WHEEL0      = 3'd0;
    localparam reg_idx_t REG_WHEEL1      = 3'd1;
    localparam reg_idx_t REG_WHEEL2      = 3'd2;
    localparam reg_idx_t REG_WHEEL3      = 3'd3;
    localparam reg_idx_t REG_SPEED_LIMIT = 3'd4;
    localparam reg_idx_t REG_FIELD_REL   = 3'd5;

    // Values that ride along the divider next to the quotient
    typedef struct packed {
        logic [15:0]        speed;
        logic signed [15:0] angle;
        logic               scale;
    } div_side_t;

    // atan(2^-i) as a 32-bit binary angle
    function automatic logic [29:0] angle_step(input int i);
        logic [29:0] a;
        case (i)
            0:       a = 30'd536870912;
            1:       a = 30'd316933406;
            2:       a = 30'd167458907;
            3:       a = 30'd85004756;
            4:       a = 30'd42667331;
            5:       a = 30'd21354465;
            6:       a = 30'd10680094;
            7:       a = 30'd5340245;
            8:       a = 30'd2670163;
            9:       a = 30'd1335087;
            10:      a = 30'd667544;
            11:      a = 30'd333772;
            12:      a = 30'd166886;
            13:      a = 30'd83443;
            14:      a = 30'd41722;
            15:      a = 30'd20861;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/swerve_inverse_kinematics_unit.sv -----
// Swerve drive inverse kinematics. Every cycle that start is high and busy
// is low, one chassis command is taken; once it has passed every pipeline
// register, done is high for one cycle with the speed and steering angle of
// every wheel. A new command may follow every cycle, so up to 58 are in
// flight. Most of the stages lie in the two 16-stage CORDIC pipelines (field
// rotation, then one vectoring lane per wheel) and the 16-stage restoring
// divider that applies speed limiting. busy is set by reset and cleared by
// the clock once reset is released. Register writes are taken whenever
// cfg_ready is high and must only be made while no command is in flight.
module swerve_inverse_kinematics_unit #(
    parameter int WHEEL_COUNT = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  velocity_x,
    input  logic signed [15:0]  velocity_y,
    input  logic signed [15:0]  turn_rate,
    input  logic [15:0]         heading,
    output logic                done,
    output logic [15:0]         speed_0,
    output logic [15:0]         speed_1,
    output logic [15:0]         speed_2,
    output logic [15:0]         speed_3,
    output logic signed [15:0]  angle_0,
    output logic signed [15:0]  angle_1,
    output logic signed [15:0]  angle_2,
    output logic signed [15:0]  angle_3,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  sik_pkg::reg_idx_t   cfg_index,
    input  logic [31:0]         cfg_data
);
    import sik_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [33:0] z;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] om;
    } rot_t;

    // Configuration
    logic        busy_reg;
    logic [31:0] offset_reg [0:NUM_SLOTS-1];
    logic [15:0] speed_limit_reg;
    logic        field_rel_reg;
    logic        cfg_we;

    assign busy      = busy_reg;
    assign cfg_ready = !busy_reg;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b1;
            speed_limit_reg <= 16'hFFFF;
            field_rel_reg   <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
                offset_reg[i] <= '0;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index <= REG_WHEEL3)
                    offset_reg[cfg_index[1:0]] <= cfg_data;
                else if (cfg_index == REG_SPEED_LIMIT)
                    speed_limit_reg <= cfg_data[15:0];
                else if (cfg_index == REG_FIELD_REL)
                    field_rel_reg <= cfg_data[0];
            end
        end
    end

    // Field rotation CORDIC, stage 0 captures and pre-rotates
    logic  rot_v_reg [0:CORDIC_STEPS];
    rot_t  rot_reg   [0:CORDIC_STEPS];
    rot_t  rot0_next;
    logic [31:0]        z_neg;
    logic signed [33:0] z_start;
    logic signed [31:0] x_in, y_in;

    assign z_neg   = 32'd0 - {heading, 16'h0000};
    assign z_start = {{2{z_neg[31]}}, z_neg};
    assign x_in    = {{4{velocity_x[15]}}, velocity_x, 12'h000};
    assign y_in    = {{4{velocity_y[15]}}, velocity_y, 12'h000};

    always_comb
    begin
        rot0_next.vx = velocity_x;
        rot0_next.vy = velocity_y;
        rot0_next.om = turn_rate;
        rot0_next.x  = x_in;
        rot0_next.y  = y_in;
        rot0_next.z  = z_start;
        if (z_start > QUARTER_Z)
        begin
            rot0_next.x = -y_in;
            rot0_next.y = x_in;
            rot0_next.z = z_start - QUARTER_Z;
        end
        else if (z_start < -QUARTER_Z)
        begin
            rot0_next.x = y_in;
            rot0_next.y = -x_in;
            rot0_next.z = z_start + QUARTER_Z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rot_v_reg[0] <= 1'b0;
        else
            rot_v_reg[0] <= start && !busy_reg;
    end

    always_ff @(posedge clk)
    begin
        rot_reg[0] <= rot0_next;
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_rot
        logic signed [31:0] dx, dy;
        logic signed [33:0] da;
        rot_t               nxt;

        assign dx = rot_reg[k].y >>> k;
        assign dy = rot_reg[k].x >>> k;
        assign da = $signed({4'b0000, angle_step(k)});

        always_comb
        begin
            nxt = rot_reg[k];
            if (!rot_reg[k].z[33])
            begin
                nxt.x = rot_reg[k].x - dx;
                nxt.y = rot_reg[k].y + dy;
                nxt.z = rot_reg[k].z - da;
            end
            else
            begin
                nxt.x = rot_reg[k].x + dx;
                nxt.y = rot_reg[k].y - dy;
                nxt.z = rot_reg[k].z + da;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rot_v_reg[k+1] <= 1'b0;
            else
                rot_v_reg[k+1] <= rot_v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            rot_reg[k+1] <= nxt;
        end
    end

    // Gain correction, rounded half up to Q.12
    rot_t               rot_last;
    logic signed [63:0] prod_x, prod_y, sum_x, sum_y;
    logic signed [31:0] kinv_s;
    logic               gv_reg;
    logic signed [31:0] gx_reg, gy_reg;
    logic signed [15:0] gvx_reg, gvy_reg, gom_reg;

    assign rot_last = rot_reg[CORDIC_STEPS];
    assign kinv_s   = $signed({2'b00, KINV});
    assign prod_x   = rot_last.x * kinv_s;
    assign prod_y   = rot_last.y * kinv_s;
    assign sum_x    = prod_x + 64'sd536870912;
    assign sum_y    = prod_y + 64'sd536870912;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gv_reg <= 1'b0;
        else
            gv_reg <= rot_v_reg[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        gx_reg  <= sum_x[61:30];
        gy_reg  <= sum_y[61:30];
        gvx_reg <= rot_last.vx;
        gvy_reg <= rot_last.vy;
        gom_reg <= rot_last.om;
    end

    // Velocity source select, then the rotational term of each wheel
    logic signed [31:0] vx_sel, vy_sel;
    logic               wv_reg, ev_reg;
    logic signed [31:0] wvx_reg, wvy_reg;
    logic signed [31:0] pa_reg [0:NUM_SLOTS-1];
    logic signed [31:0] pb_reg [0:NUM_SLOTS-1];
    logic signed [33:0] ex_reg [0:NUM_SLOTS-1];
    logic signed [33:0] ey_reg [0:NUM_SLOTS-1];

    assign vx_sel = field_rel_reg ? gx_reg : {{4{gvx_reg[15]}}, gvx_reg, 12'h000};
    assign vy_sel = field_rel_reg ? gy_reg : {{4{gvy_reg[15]}}, gvy_reg, 12'h000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg <= 1'b0;
            ev_reg <= 1'b0;
        end
        else
        begin
            wv_reg <= gv_reg;
            ev_reg <= wv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wvx_reg <= vx_sel;
        wvy_reg <= vy_sel;
    end

    // Per-wheel lanes
    logic [15:0]        lane_speed [0:NUM_SLOTS-1];
    logic signed [15:0] lane_angle [0:NUM_SLOTS-1];
    logic               lane_valid [0:NUM_SLOTS-1];

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_wheel
        if (i < WHEEL_COUNT)
        begin : g_used
            logic signed [15:0] ox, oy;

            assign ox = $signed(offset_reg[i][15:0]);
            assign oy = $signed(offset_reg[i][31:16]);

            always_ff @(posedge clk)
            begin
                pa_reg[i] <= gom_reg * oy;
                pb_reg[i] <= gom_reg * ox;
                ex_reg[i] <= {{2{wvx_reg[31]}}, wvx_reg} - {{2{pa_reg[i][31]}}, pa_reg[i]};
                ey_reg[i] <= {{2{wvy_reg[31]}}, wvy_reg} + {{2{pb_reg[i][31]}}, pb_reg[i]};
            end

            sik_vec u_vec (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (ev_reg),
                .in_x      (ex_reg[i]),
                .in_y      (ey_reg[i]),
                .out_valid (lane_valid[i]),
                .speed     (lane_speed[i]),
                .angle     (lane_angle[i])
            );
        end
        else
        begin : g_unused
            assign pa_reg[i]     = '0;
            assign pb_reg[i]     = '0;
            assign ex_reg[i]     = '0;
            assign ey_reg[i]     = '0;
            assign lane_valid[i] = 1'b0;
            assign lane_speed[i] = '0;
            assign lane_angle[i] = '0;
        end
    end

    // Largest speed over the wheels
    logic               mv_reg;
    logic [15:0]        largest_next, largest_reg;
    logic [15:0]        ms_reg [0:NUM_SLOTS-1];
    logic signed [15:0] ma_reg [0:NUM_SLOTS-1];

    always_comb
    begin
        largest_next = '0;
        for (int i = 0; i < WHEEL_COUNT; i++)
            if (lane_speed[i] > largest_next)
                largest_next = lane_speed[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else
            mv_reg <= lane_valid[0];
    end

    always_ff @(posedge clk)
    begin
        largest_reg <= largest_next;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            ms_reg[i] <= lane_speed[i];
            ma_reg[i] <= lane_angle[i];
        end
    end

    // Scale numerators, then divide by the largest speed
    logic        nv_reg;
    logic [31:0] num_reg  [0:NUM_SLOTS-1];
    logic [15:0] den_reg;
    div_side_t   side_reg [0:NUM_SLOTS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nv_reg <= 1'b0;
        else
            nv_reg <= mv_reg;
    end

    always_ff @(posedge clk)
    begin
        den_reg <= largest_reg;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            num_reg[i]        <= ms_reg[i] * speed_limit_reg;
            side_reg[i].speed <= ms_reg[i];
            side_reg[i].angle <= ma_reg[i];
            side_reg[i].scale <= largest_reg > speed_limit_reg;
        end
    end

    logic               dv   [0:NUM_SLOTS-1];
    logic [15:0]        dq   [0:NUM_SLOTS-1];
    div_side_t          dside [0:NUM_SLOTS-1];

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_div
        if (i < WHEEL_COUNT)
        begin : g_used
            sik_div u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (nv_reg),
                .num       (num_reg[i]),
                .den       (den_reg),
                .in_side   (side_reg[i]),
                .out_valid (dv[i]),
                .quo       (dq[i]),
                .out_side  (dside[i])
            );
        end
        else
        begin : g_unused
            assign dv[i]    = 1'b0;
            assign dq[i]    = '0;
            assign dside[i] = '0;
        end
    end

    // Output register
    logic               done_reg;
    logic [15:0]        so_reg [0:NUM_SLOTS-1];
    logic signed [15:0] ao_reg [0:NUM_SLOTS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv[0];
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            so_reg[i] <= dside[i].scale ? dq[i] : dside[i].speed;
            ao_reg[i] <= dside[i].angle;
        end
    end

    assign done    = done_reg;
    assign speed_0 = so_reg[0];
    assign speed_1 = so_reg[1];
    assign speed_2 = so_reg[2];
    assign speed_3 = so_reg[3];
    assign angle_0 = ao_reg[0];
    assign angle_1 = ao_reg[1];
    assign angle_2 = ao_reg[2];
    assign angle_3 = ao_reg[3];

    // Limit scaling never leaves a wheel above the limit
    a_speed_limit : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (speed_0 <= speed_limit_reg) && (speed_1 <= speed_limit_reg)
              && (speed_2 <= speed_limit_reg) && (speed_3 <= speed_limit_reg))
        else $error("wheel speed above the speed limit");

    // A missing wheel 3 reports zero
    a_unused_wheel : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (WHEEL_COUNT > 3) || ((speed_3 == 16'd0) && (angle_3 == 16'sd0)))
        else $error("unused wheel output not zero");

endmodule

// ----- rtl/sik_vec.sv -----
module sik_vec (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [33:0]  in_x,
    input  logic signed [33:0]  in_y,
    output logic                out_valid,
    output logic [15:0]         speed,
    output logic signed [15:0]  angle
);
    import sik_pkg::*;

    logic               v_reg    [0:CORDIC_STEPS];
    logic               zero_reg [0:CORDIC_STEPS];
    logic signed [37:0] x_reg    [0:CORDIC_STEPS];
    logic signed [37:0] y_reg    [0:CORDIC_STEPS];
    logic signed [33:0] z_reg    [0:CORDIC_STEPS];

    logic signed [37:0] x0_next, y0_next, xe, ye;
    logic signed [33:0] z0_next;

    // Turn left-half-plane vectors into the right half plane
    always_comb
    begin
        xe = {{4{in_x[33]}}, in_x};
        ye = {{4{in_y[33]}}, in_y};
        x0_next = xe;
        y0_next = ye;
        z0_next = '0;
        if (in_x[33])
        begin
            if (!in_y[33])
            begin
                x0_next = ye;
                y0_next = -xe;
                z0_next = QUARTER_Z;
            end
            else
            begin
                x0_next = -ye;
                y0_next = xe;
                z0_next = -QUARTER_Z;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]    <= x0_next;
        y_reg[0]    <= y0_next;
        z_reg[0]    <= z0_next;
        zero_reg[0] <= (in_x == '0) && (in_y == '0);
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_iter
        logic signed [37:0] dx, dy;
        logic signed [33:0] da;

        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;
        assign da = $signed({4'b0000, angle_step(k)});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            zero_reg[k+1] <= zero_reg[k];
            if (!y_reg[k][37])
            begin
                x_reg[k+1] <= x_reg[k] + dx;
                y_reg[k+1] <= y_reg[k] - dy;
                z_reg[k+1] <= z_reg[k] + da;
            end
            else
            begin
                x_reg[k+1] <= x_reg[k] - dx;
                y_reg[k+1] <= y_reg[k] + dy;
                z_reg[k+1] <= z_reg[k] - da;
            end
        end
    end

    // Gain correction split into two 18 x 30 partial products
    logic [47:0]        p_hi_reg, p_lo_reg;
    logic               mv_reg, mzero_reg;
    logic signed [15:0] mangle_reg;
    logic signed [33:0] z_round;
    logic [35:0]        x_mag;

    assign x_mag   = x_reg[CORDIC_STEPS][35:0];
    assign z_round = z_reg[CORDIC_STEPS] + 34'sd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mv_reg <= 1'b0;
        else
            mv_reg <= v_reg[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        p_hi_reg   <= x_mag[35:18] * KINV;
        p_lo_reg   <= x_mag[17:0] * KINV;
        mzero_reg  <= zero_reg[CORDIC_STEPS] || x_reg[CORDIC_STEPS][37];
        mangle_reg <= zero_reg[CORDIC_STEPS] ? 16'sd0 : $signed(z_round[31:16]);
    end

    logic [66:0]        mag_sum;
    logic [24:0]        mag;
    logic               sv_reg;
    logic [15:0]        speed_reg;
    logic signed [15:0] angle_reg;

    assign mag_sum = {1'b0, p_hi_reg, 18'b0} + {19'b0, p_lo_reg} + (67'd1 << 41);
    assign mag     = mag_sum[66:42];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sv_reg <= 1'b0;
        else
            sv_reg <= mv_reg;
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= mangle_reg;
        if (mzero_reg)
            speed_reg <= 16'd0;
        else if (mag > 25'd65535)
            speed_reg <= 16'hFFFF;
        else
            speed_reg <= mag[15:0];
    end

    assign out_valid = sv_reg;
    assign speed     = speed_reg;
    assign angle     = angle_reg;

endmodule

// ----- rtl/sik_div.sv -----
module sik_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [31:0]          num,
    input  logic [15:0]          den,
    input  sik_pkg::div_side_t   in_side,
    output logic                 out_valid,
    output logic [15:0]          quo,
    output sik_pkg::div_side_t   out_side
);
    import sik_pkg::*;

    localparam int STEPS = 16;

    logic        v_reg    [0:STEPS-1];
    logic [15:0] rem_reg  [0:STEPS-1];
    logic [31:0] num_reg  [0:STEPS-1];
    logic [15:0] den_reg  [0:STEPS-1];
    logic [15:0] q_reg    [0:STEPS-1];
    div_side_t   side_reg [0:STEPS-1];

    logic        v_stage    [0:STEPS];
    logic [15:0] rem_stage  [0:STEPS];
    logic [31:0] num_stage  [0:STEPS];
    logic [15:0] den_stage  [0:STEPS];
    logic [15:0] q_stage    [0:STEPS];
    div_side_t   side_stage [0:STEPS];

    assign v_stage[0]    = in_valid;
    assign rem_stage[0]  = num[31:16];
    assign num_stage[0]  = num;
    assign den_stage[0]  = den;
    assign q_stage[0]    = '0;
    assign side_stage[0] = in_side;

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [16:0] trial;
        logic        ge;
        logic [16:0] diff;
        logic [15:0] q_next;

        assign trial = {rem_stage[k], num_stage[k][STEPS-1-k]};
        assign ge    = trial >= {1'b0, den_stage[k]};
        assign diff  = trial - {1'b0, den_stage[k]};

        always_comb
        begin
            q_next = q_stage[k];
            q_next[STEPS-1-k] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else
                v_reg[k] <= v_stage[k];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? diff[15:0] : trial[15:0];
            num_reg[k]  <= num_stage[k];
            den_reg[k]  <= den_stage[k];
            q_reg[k]    <= q_next;
            side_reg[k] <= side_stage[k];
        end

        assign v_stage[k+1]    = v_reg[k];
        assign rem_stage[k+1]  = rem_reg[k];
        assign num_stage[k+1]  = num_reg[k];
        assign den_stage[k+1]  = den_reg[k];
        assign q_stage[k+1]    = q_reg[k];
        assign side_stage[k+1] = side_reg[k];
    end

    assign out_valid = v_stage[STEPS];
    assign quo       = q_stage[STEPS];
    assign out_side  = side_stage[STEPS];

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import sik_pkg::*;

    localparam int LATENCY = 58;
    localparam int WHEELS  = 4;

    typedef struct {
        logic [15:0]        speed [4];
        logic signed [15:0] angle [4];
    } wheel_set_t;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] w;
        logic [15:0]        hdg;
        bit                 typed;
        wheel_set_t         res;
    } cmd_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] velocity_x;
    logic signed [15:0] velocity_y;
    logic signed [15:0] turn_rate;
    logic [15:0]        heading;
    logic               done;
    logic [15:0]        speed_0, speed_1, speed_2, speed_3;
    logic signed [15:0] angle_0, angle_1, angle_2, angle_3;
    logic               cfg_valid;
    logic               cfg_ready;
    reg_idx_t           cfg_index;
    logic [31:0]        cfg_data;

    swerve_inverse_kinematics_unit #(.WHEEL_COUNT(WHEELS)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .velocity_x(velocity_x), .velocity_y(velocity_y),
        .turn_rate(turn_rate), .heading(heading), .done(done),
        .speed_0(speed_0), .speed_1(speed_1), .speed_2(speed_2), .speed_3(speed_3),
        .angle_0(angle_0), .angle_1(angle_1), .angle_2(angle_2), .angle_3(angle_3),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // local copy of the register file
    logic [31:0] offset_reg [4];
    logic [15:0] limit_reg;
    logic        field_rel_reg;

    wheel_set_t  pending_wheels [$];
    int          error_count;

    localparam longint QTURN = 64'sd1073741824;
    localparam longint FTURN = 64'sd4294967296;

    function automatic longint atan_step(input int i);
        longint t [16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
            21354465, 10680094, 5340245, 2670163, 1335087, 667544, 333772,
            166886, 83443, 41722, 20861};
        return t[i];
    endfunction

    function automatic void field_rotate(inout longint x, inout longint y,
                                         input longint z);
        longint t, dx, dy;
        if (z > QTURN) begin
            t = x; x = -y; y = t; z -= QTURN;
        end else if (z < -QTURN) begin
            t = x; x = y; y = -t; z += QTURN;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        x = (x * 64'sd652032874 + (64'sd1 <<< 29)) >>> 30;
        y = (y * 64'sd652032874 + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic void to_polar(input longint x, input longint y,
                                     output logic [15:0] spd,
                                     output logic [15:0] ang);
        longint z, t, m, dx, dy;
        z = 0;
        if (x == 0 && y == 0) begin
            spd = '0; ang = '0;
            return;
        end
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = QTURN;
            end else begin
                t = x; x = -y; y = t; z = -QTURN;
            end
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        m = (x * 64'sd652032874 + (64'sd1 <<< 41)) >>> 42;
        if (m < 0) m = 0;
        if (m > 65535) m = 65535;
        spd = m[15:0];
        z = (z + 64'sd32768) >>> 16;
        ang = z[15:0];
    endfunction

    function automatic wheel_set_t wheel_targets(input logic signed [15:0] vx_in,
        input logic signed [15:0] vy_in, input logic signed [15:0] w_in,
        input logic [15:0] hdg);
        wheel_set_t r;
        longint vx, vy, w, ox, oy, z;
        logic [15:0] s, a;
        longint top;
        vx = longint'(vx_in) * 4096;
        vy = longint'(vy_in) * 4096;
        w  = longint'(w_in);
        top = 0;
        for (int i = 0; i < 4; i++) begin
            r.speed[i] = '0;
            r.angle[i] = '0;
        end
        if (field_rel_reg) begin
            z = (FTURN - (longint'(hdg) <<< 16)) & 64'hFFFF_FFFF;
            if (z >= FTURN / 2) z -= FTURN;
            field_rotate(vx, vy, z);
        end
        for (int i = 0; i < WHEELS; i++) begin
            ox = longint'($signed(offset_reg[i][15:0]));
            oy = longint'($signed(offset_reg[i][31:16]));
            to_polar(vx - w * oy, vy + w * ox, s, a);
            r.speed[i] = s;
            r.angle[i] = a;
            if (s > top) top = s;
        end
        if (top > limit_reg)
            for (int i = 0; i < WHEELS; i++)
                r.speed[i] = 16'((longint'(r.speed[i]) * limit_reg) / top);
        return r;
    endfunction

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // results cannot be held off: sample every done pulse
    always @(posedge clk)
    begin
        wheel_set_t want;
        logic [15:0] got_s [4];
        logic [15:0] got_a [4];
        if (rst_n && done) begin
            got_s = '{speed_0, speed_1, speed_2, speed_3};
            got_a = '{angle_0, angle_1, angle_2, angle_3};
            if (pending_wheels.size() == 0) begin
                $error("unexpected result");
                error_count++;
            end else begin
                want = pending_wheels.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got_s[i] !== want.speed[i]) begin
                        $error("speed_%0d expected %0d got %0d", i, want.speed[i], got_s[i]);
                        error_count++;
                    end
                    if (got_a[i] !== want.angle[i]) begin
                        $error("angle_%0d expected %0d got %0d", i, $signed(want.angle[i]),
                               $signed(got_a[i]));
                        error_count++;
                    end
                end
            end
        end
    end

    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 40))
                                           : int'($urandom_range(0, 2));
    endfunction

    // the caller drops cfg_valid after its last write
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx <= REG_WHEEL3)
            offset_reg[idx[1:0]] = value;
        else if (idx == REG_SPEED_LIMIT)
            limit_reg = value[15:0];
        else if (idx == REG_FIELD_REL)
            field_rel_reg = value[0];
    endtask

    task automatic drain();
        while (pending_wheels.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send_command(input logic signed [15:0] vx, input logic signed [15:0] vy,
                                input logic signed [15:0] w, input logic [15:0] hdg,
                                input bit gaps);
        int n;
        start      <= 1'b1;
        velocity_x <= vx;
        velocity_y <= vy;
        turn_rate  <= w;
        heading    <= hdg;
        do @(posedge clk); while (busy);
        pending_wheels.push_back(wheel_targets(vx, vy, w, hdg));
        if (gaps && $urandom_range(0, 3) == 0) begin
            n = gap_length();
            if (n > 0) begin
                start <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    endtask

    function automatic logic signed [15:0] random_field();
        case ($urandom_range(0, 5))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($urandom_range(0, 2) - 1);
            3:       return 16'($signed($urandom_range(0, 2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        cmd_row_t rows [$];
        cmd_row_t row;
        wheel_set_t zero_set;
        int phase_count;

        error_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        velocity_x = '0; velocity_y = '0; turn_rate = '0; heading = '0;
        cfg_valid = 1'b0; cfg_index = REG_WHEEL0; cfg_data = '0;
        for (int i = 0; i < 4; i++) offset_reg[i] = '0;
        limit_reg = 16'hFFFF;
        field_rel_reg = 1'b0;
        for (int i = 0; i < 4; i++) begin
            zero_set.speed[i] = '0;
            zero_set.angle[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero vector after reset: all zero
        row = '{vx: 0, vy: 0, w: 0, hdg: 0, typed: 1, res: zero_set};
        rows.push_back(row);
        // pure +x at 1000 mm/s, all wheels at the origin
        row.vx = 1000; row.res.speed = '{1000, 1000, 1000, 1000};
        rows.push_back(row);
        foreach (rows[k])
        begin
            if (rows[k].typed) begin
                pending_wheels.push_back(rows[k].res);
                start <= 1'b1;
                velocity_x <= rows[k].vx; velocity_y <= rows[k].vy;
                turn_rate <= rows[k].w; heading <= rows[k].hdg;
                do @(posedge clk); while (busy);
            end
        end
        start <= 1'b0;
        drain();

        // directed: corners, wheel layout, field-relative, limit
        write_reg(REG_WHEEL0, {16'sd300, 16'sd300});
        write_reg(REG_WHEEL1, {16'sd300, -16'sd300});
        write_reg(REG_WHEEL2, {-16'sd300, -16'sd300});
        write_reg(REG_WHEEL3, {16'h8000, 16'h7FFF});
        write_reg(3'd6, 32'hFFFF_FFFF);
        write_reg(3'd7, 32'h0);
        cfg_valid <= 1'b0;
        rows.delete();
        for (int k = 0; k < 16; k++) begin
            row.typed = 0;
            row.vx = (k & 1) ? 16'sh7FFF : 16'sh8000;
            row.vy = (k & 2) ? 16'sh7FFF : 16'sh8000;
            row.w  = (k & 4) ? 16'sh7FFF : 16'sh8000;
            row.hdg = (k & 8) ? 16'hFFFF : 16'h0000;
            rows.push_back(row);
        end
        row.vx = -500; row.vy = 0; row.w = 0; row.hdg = 16'h4000; rows.push_back(row);
        row.vx = 0; row.vy = 0; row.w = 4096; rows.push_back(row);
        row.vx = 0; row.vy = -1; row.w = 0; rows.push_back(row);
        foreach (rows[k]) send_command(rows[k].vx, rows[k].vy, rows[k].w, rows[k].hdg, 0);
        start <= 1'b0;
        drain();
        write_reg(REG_FIELD_REL, 32'h1);
        write_reg(REG_SPEED_LIMIT, 32'd0);
        cfg_valid <= 1'b0;
        foreach (rows[k]) send_command(rows[k].vx, rows[k].vy, rows[k].w, rows[k].hdg, 0);
        start <= 1'b0;
        drain();

        // random phases with fresh settings
        phase_count = 0;
        while (phase_count < 8)
        begin
            for (int i = 0; i < 4; i++)
                write_reg(reg_idx_t'(i), ($urandom_range(0, 3) == 0) ? $urandom
                          : {16'($signed($urandom_range(0, 1200)) - 600),
                             16'($signed($urandom_range(0, 1200)) - 600)});
            case (phase_count % 4)
                0:       write_reg(REG_SPEED_LIMIT, 32'hFFFF);
                1:       write_reg(REG_SPEED_LIMIT, 32'd0);
                default: write_reg(REG_SPEED_LIMIT, $urandom_range(1, 65535));
            endcase
            write_reg(REG_FIELD_REL, {$urandom} & ~32'h0 & ($urandom_range(0, 1) ? 32'hFFFF_FFFF
                                                                             : 32'hFFFF_FFFE));
            cfg_valid <= 1'b0;
            for (int n = 0; n < 235; n++)
                send_command(random_field(), random_field(), random_field(),
                             16'($urandom), 1);
            start <= 1'b0;
            drain();
            phase_count++;
        end

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
